@@ rtl/kmpsm_pkg.sv @@
// kmpsm_pkg: shared types, widths and codes of the streaming kmp matcher
// no dependencies; imported by every module of the block
package kmpsm_pkg;

    // fixed widths of the pattern registers and the length fields
    localparam int BYTE_W             = 8;
    localparam int PAT_BYTES          = 16;
    localparam int PIDX_W             = $clog2(PAT_BYTES);
    localparam int LEN_W              = 5;
    localparam int CFG_W              = 64;
    localparam int CFG_IDX_W          = 2;
    localparam int START_W            = 32;

    // defaults for the top level parameters
    localparam int DEF_MAX_PATTERN    = 16;
    localparam int DEF_POSITION_WIDTH = 32;

    // depth of the queue between front and engine
    localparam int QUEUE_DEPTH        = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd2;

    // one queued text beat
    typedef struct packed {
        logic              first;
        logic [BYTE_W-1:0] text_byte;
    } item_t;

    // pattern bytes, byte 0 in the low bits
    typedef logic [PAT_BYTES-1:0][BYTE_W-1:0] pat_t;

    // status of the pattern table toward the engine
    typedef struct packed {
        logic             busy;
        logic             clear;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] full_fail;
        logic [LEN_W-1:0] ft_rdata;
    } tbl_info_t;

    // engine states
    typedef enum logic [0:0] {
        ENG_IDLE,
        ENG_STEP
    } eng_state_t;

endpackage

@@ rtl/kmp_stream_pattern_matcher_unit.sv @@
// kmp_stream_pattern_matcher_unit: the engine does one pattern compare per cycle unless it waits
// on a full result register or a table rebuild; each failure fallback is a compare of its own.
// a configuration write to a pattern or length register rebuilds the failure table, cfg_ready low.
// reset (rst_n, async, active low) clears control, position and matched length, and sets a
// one-byte zero pattern whose all-zero table is loaded at once; no clearing pass.
module kmp_stream_pattern_matcher_unit
    import kmpsm_pkg::*;
#(
    parameter int MAX_PATTERN    = DEF_MAX_PATTERN,
    parameter int POSITION_WIDTH = DEF_POSITION_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    text_byte,
    input  logic                 first_of_text,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 match_found,
    output logic [START_W-1:0]   match_start
);

    logic             q_valid;
    item_t            q_item;
    logic             q_pop;
    pat_t             pat;
    tbl_info_t        info;
    logic [LEN_W-1:0] eng_m;

    // input beats into the queue
    kmpsm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .text_byte     (text_byte),
        .first_of_text (first_of_text),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    // pattern registers and failure table
    kmpsm_table #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .eng_m     (eng_m),
        .pat       (pat),
        .info      (info)
    );

    // match walk and result register
    kmpsm_engine #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .pat         (pat),
        .info        (info),
        .eng_m       (eng_m),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .match_found (match_found),
        .match_start (match_start)
    );

endmodule

@@ rtl/kmpsm_front.sv @@
// kmpsm_front: input handshake and a short queue of text beats
// depends on kmpsm_pkg
module kmpsm_front
    import kmpsm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] text_byte,
    input  logic              first_of_text,
    output logic              q_valid,
    output item_t             q_item,
    input  logic              q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             q_mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push;

    // handshake and queue status
    assign in_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = q_mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= '{first: first_of_text, text_byte: text_byte};
        end
    end

    // checks
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (count_reg != '0))
        else $error("queue popped while empty");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (push && q_pop) |=> $stable(count_reg))
        else $error("fill count moved on simultaneous push and pop");

endmodule

@@ rtl/kmpsm_table.sv @@
// kmpsm_table: pattern registers, configuration port and failure table builder
// depends on kmpsm_pkg
module kmpsm_table
    import kmpsm_pkg::*;
#(
    parameter int MAX_PATTERN = DEF_MAX_PATTERN
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [LEN_W-1:0]     eng_m,
    output pat_t                 pat,
    output tbl_info_t            info
);

    localparam int IDX_W = $clog2(MAX_PATTERN);

    logic [CFG_W-1:0] pat_low_reg;
    logic [CFG_W-1:0] pat_high_reg;
    logic [LEN_W-1:0] len_raw_reg;
    logic [LEN_W-1:0] ft_reg [MAX_PATTERN];
    logic             busy_reg, busy_next;
    logic [LEN_W-1:0] i_reg, i_next;
    logic [LEN_W-1:0] k_reg, k_next;
    logic [LEN_W-1:0] full_fail_reg, full_fail_next;
    logic [LEN_W-1:0] len_used;
    logic [IDX_W-1:0] rd_addr;
    logic [LEN_W-1:0] ft_rdata;
    logic [LEN_W-1:0] build_k;
    logic             ft_we;
    logic             cfg_fire;
    logic             cfg_hit;
    logic             byte_eq;

    assign cfg_ready = !busy_reg;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_fire && ((cfg_index == CFG_PAT_LOW) || (cfg_index == CFG_PAT_HIGH)
                                    || (cfg_index == CFG_PAT_LEN));
    assign pat       = {pat_high_reg, pat_low_reg};

    // length in use, clamped to one and to the table depth
    always_comb
    begin
        if (len_raw_reg == '0)
        begin
            len_used = LEN_W'(1);
        end
        else if (len_raw_reg > LEN_W'(MAX_PATTERN))
        begin
            len_used = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            len_used = len_raw_reg;
        end
    end

    // single table read port, builder while busy, engine otherwise
    assign rd_addr  = busy_reg ? IDX_W'(k_reg - 1'b1) : IDX_W'(eng_m - 1'b1);
    assign ft_rdata = ft_reg[rd_addr];

    // one compare of the prefix-suffix walk per cycle
    assign byte_eq  = (pat[PIDX_W'(i_reg)] == pat[PIDX_W'(k_reg)]);
    assign build_k  = k_reg + LEN_W'(byte_eq);

    always_comb
    begin
        busy_next      = busy_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        full_fail_next = full_fail_reg;
        ft_we          = 1'b0;
        if (cfg_hit)
        begin
            busy_next      = 1'b1;
            i_next         = LEN_W'(1);
            k_next         = '0;
            full_fail_next = '0;
        end
        else if (busy_reg)
        begin
            if (i_reg >= len_used)
            begin
                busy_next = 1'b0;
            end
            else if ((k_reg != '0) && !byte_eq)
            begin
                k_next = ft_rdata;
            end
            else
            begin
                ft_we  = 1'b1;
                k_next = build_k;
                i_next = i_reg + 1'b1;
                if (i_reg == len_used - 1'b1)
                begin
                    full_fail_next = build_k;
                end
            end
        end
    end

    // builder control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            i_reg         <= '0;
            k_reg         <= '0;
            full_fail_reg <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            full_fail_reg <= full_fail_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            len_raw_reg  <= LEN_W'(1);
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                CFG_PAT_LOW:  pat_low_reg  <= cfg_data;
                CFG_PAT_HIGH: pat_high_reg <= cfg_data;
                CFG_PAT_LEN:  len_raw_reg  <= cfg_data[LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    // failure table, reset gives the table of the reset pattern
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < MAX_PATTERN; e++)
            begin
                ft_reg[e] <= '0;
            end
        end
        else if (ft_we)
        begin
            ft_reg[IDX_W'(i_reg)] <= build_k;
        end
    end

    // status toward the engine
    assign info.busy      = busy_reg;
    assign info.clear     = cfg_hit;
    assign info.len       = len_used;
    assign info.full_fail = full_fail_reg;
    assign info.ft_rdata  = ft_rdata;

    // checks
    a_k_below_i: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (k_reg < i_reg))
        else $error("prefix length not below build index");

    a_i_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (i_reg <= len_used))
        else $error("build index past pattern length");

endmodule

@@ rtl/kmpsm_engine.sv @@
// kmpsm_engine: per-byte match walk, position counter and result register
// depends on kmpsm_pkg; pattern and failure table come from kmpsm_table
module kmpsm_engine
    import kmpsm_pkg::*;
#(
    parameter int POSITION_WIDTH = DEF_POSITION_WIDTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  item_t              q_item,
    output logic               q_pop,
    input  pat_t               pat,
    input  tbl_info_t          info,
    output logic [LEN_W-1:0]   eng_m,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               match_found,
    output logic [START_W-1:0] match_start
);

    eng_state_t                state_reg, state_next;
    logic [LEN_W-1:0]          m_reg, m_next;
    logic [POSITION_WIDTH-1:0] pos_reg, pos_next;
    logic [BYTE_W-1:0]         c_reg, c_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      found_reg, found_next;
    logic [START_W-1:0]        start_reg, start_next;
    logic                      out_write;
    logic                      slot_free;
    logic                      byte_eq;
    logic [LEN_W-1:0]          m_inc;
    logic                      hit;
    logic [POSITION_WIDTH-1:0] len_m1;
    logic [POSITION_WIDTH-1:0] start_pos;
    logic [POSITION_WIDTH-1:0] pos_inc;

    assign eng_m = m_reg;

    // compare and result arithmetic for the current matched length
    assign byte_eq   = (pat[PIDX_W'(m_reg)] == c_reg);
    assign m_inc     = m_reg + LEN_W'(byte_eq);
    assign hit       = (m_inc >= info.len);
    assign len_m1    = POSITION_WIDTH'(info.len - 1'b1);
    assign start_pos = (pos_reg >= len_m1) ? (pos_reg - len_m1) : '0;
    assign pos_inc   = (&pos_reg) ? pos_reg : (pos_reg + 1'b1);
    assign slot_free = !out_valid_reg || out_ready;

    // next state and outputs
    always_comb
    begin
        state_next = state_reg;
        m_next     = m_reg;
        pos_next   = pos_reg;
        c_next     = c_reg;
        found_next = found_reg;
        start_next = start_reg;
        q_pop      = 1'b0;
        out_write  = 1'b0;
        if (info.clear)
        begin
            m_next = '0;
        end
        case (state_reg)
            ENG_IDLE:
            begin
                if (q_valid && !info.busy)
                begin
                    q_pop      = 1'b1;
                    c_next     = q_item.text_byte;
                    state_next = ENG_STEP;
                    if (q_item.first)
                    begin
                        m_next   = '0;
                        pos_next = '0;
                    end
                end
            end
            ENG_STEP:
            begin
                if ((m_reg != '0) && !byte_eq)
                begin
                    // fall back through the failure table
                    m_next = info.ft_rdata;
                end
                else if (slot_free)
                begin
                    out_write  = 1'b1;
                    found_next = hit;
                    start_next = hit ? START_W'(start_pos) : '0;
                    m_next     = hit ? info.full_fail : m_inc;
                    pos_next   = pos_inc;
                    // chain straight into the next queued beat
                    if (q_valid && !info.busy)
                    begin
                        q_pop  = 1'b1;
                        c_next = q_item.text_byte;
                        if (q_item.first)
                        begin
                            m_next   = '0;
                            pos_next = '0;
                        end
                    end
                    else
                    begin
                        state_next = ENG_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ENG_IDLE;
            end
        endcase
        out_valid_next = out_write ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ENG_IDLE;
            m_reg         <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            m_reg         <= m_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        c_reg     <= c_next;
        found_reg <= found_next;
        start_reg <= start_next;
    end

    assign out_valid   = out_valid_reg;
    assign match_found = found_reg;
    assign match_start = start_reg;

    // checks
    a_m_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        !info.busy |-> (m_reg < info.len))
        else $error("matched length not below pattern length");

    a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |-> (start_reg == '0))
        else $error("start position set without a match");

    a_idle_on_build: assert property (@(posedge clk) disable iff (!rst_n)
        info.busy |-> (state_reg == ENG_IDLE))
        else $error("engine active while the table is built");

endmodule

@@ bench/tb_kmp_stream_pattern_matcher_unit.sv @@
// tb_kmp_stream_pattern_matcher_unit: drives text beats and pattern writes into the kmp matcher,
// predicts every match flag and start position, and compares each result beat in order
// depends on kmpsm_pkg and kmp_stream_pattern_matcher_unit
`timescale 1ns / 100ps

module tb_kmp_stream_pattern_matcher_unit;
    import kmpsm_pkg::*;

    // index past the last register, writes to it change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_GAP     = 13;

    typedef struct packed {
        logic               found;
        logic [START_W-1:0] start;
    } match_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [BYTE_W-1:0]    text_byte;
    logic                 first_of_text;
    logic                 out_valid;
    logic                 out_ready;
    logic                 match_found;
    logic [START_W-1:0]   match_start;

    // predicted matcher state
    logic [CFG_W-1:0]     pattern_lo;
    logic [CFG_W-1:0]     pattern_hi;
    logic [LEN_W-1:0]     pattern_len_reg;
    logic [LEN_W-1:0]     match_len;
    logic [START_W-1:0]   next_pos;
    logic [LEN_W-1:0]     fail_tab [PAT_BYTES];

    match_t expected_matches[$];
    match_t want;
    int     mismatches  = 0;
    int     cycle_count = 0;
    int     ready_stall;
    bit     idle_on     = 1'b1;

    kmp_stream_pattern_matcher_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .text_byte     (text_byte),
        .first_of_text (first_of_text),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .match_found   (match_found),
        .match_start   (match_start)
    );

    always #4 clk = ~clk;

    // pattern length actually used, out-of-range values clamped
    function automatic int eff_len();
        int n;
        n = pattern_len_reg;
        if (n == 0)
            n = 1;
        if (n > PAT_BYTES)
            n = PAT_BYTES;
        return n;
    endfunction

    function automatic logic [7:0] pat_at(input int k);
        int j;
        j = k & 15;
        if (j < 8)
            return pattern_lo[8*j +: 8];
        return pattern_hi[8*(j-8) +: 8];
    endfunction

    // longest proper prefix-suffix for each pattern prefix
    function automatic void rebuild_failure();
        int n;
        int k;
        n = eff_len();
        k = 0;
        for (int i = 0; i < PAT_BYTES; i++)
            fail_tab[i] = '0;
        for (int i = 1; i < n; i++)
        begin
            while (k > 0 && pat_at(i) != pat_at(k))
                k = fail_tab[(k - 1) & 15];
            if (pat_at(i) == pat_at(k))
                k++;
            fail_tab[i] = LEN_W'(k);
        end
        match_len = '0;
    endfunction

    function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] data);
        case (idx)
            CFG_PAT_LOW:  pattern_lo = data;
            CFG_PAT_HIGH: pattern_hi = data;
            CFG_PAT_LEN:  pattern_len_reg = data[LEN_W-1:0];
            default:      return;
        endcase
        rebuild_failure();
    endfunction

    // advance the predicted matcher by one text byte
    function automatic match_t step_matcher(input logic [7:0] c, input logic restart);
        match_t           r;
        int               n;
        int               m;
        logic [START_W-1:0] pos;
        r = '0;
        n = eff_len();
        if (restart)
        begin
            match_len = '0;
            next_pos  = '0;
        end
        pos = next_pos;
        m = match_len;
        if (m >= n)
            m = 0;
        while (m > 0 && pat_at(m) != c)
            m = fail_tab[(m - 1) & 15];
        if (pat_at(m) == c)
            m++;
        if (m >= n)
        begin
            r.found = 1'b1;
            r.start = (pos >= START_W'(n - 1)) ? pos - START_W'(n - 1) : '0;
            m = fail_tab[(n - 1) & 15];
        end
        match_len = LEN_W'(m);
        next_pos  = (pos == '1) ? pos : pos + 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // one text beat, with a random gap before it while idle_on is set
    task automatic send_text(input logic [7:0] txt, input logic restart);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid      = 1'b1;
        text_byte     = txt;
        first_of_text = restart;
        do @(posedge clk); while (!in_ready);
        expected_matches.push_back(step_matcher(txt, restart));
    endtask

    // stop sending and hold off until every result beat is back
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_matches.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        apply_config(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // reset pattern is a single zero byte
    task automatic test_reset_pattern();
        send_text(8'h00, 1'b1);
        send_text(8'hFF, 1'b0);
        send_text(8'h00, 1'b0);
    endtask

    // length above the maximum clamps to 16, overlapping occurrence follows
    task automatic test_long_pattern();
        wait_idle();
        cfg_write(CFG_PAT_LOW, '1);
        cfg_write(CFG_PAT_HIGH, '1);
        cfg_write(CFG_PAT_LEN, 64'd31);
        for (int i = 0; i < 17; i++)
            send_text(8'hFF, i == 0);
    endtask

    // matched length across unused writes, restarts and length rewrites
    task automatic test_match_state();
        wait_idle();
        cfg_write(CFG_PAT_LOW, 64'h4241);
        cfg_write(CFG_PAT_LEN, 64'd2);
        send_text(8'h41, 1'b1);
        wait_idle();
        cfg_write(CFG_UNUSED, {$urandom, $urandom});
        send_text(8'h42, 1'b0);
        send_text(8'h41, 1'b0);
        send_text(8'h42, 1'b1);
        send_text(8'h41, 1'b0);
        wait_idle();
        cfg_write(CFG_PAT_LEN, 64'd2);
        send_text(8'h42, 1'b0);
        send_text(8'h41, 1'b0);
        send_text(8'h42, 1'b0);
    endtask

    // random patterns over small alphabets, text mostly built from the pattern
    task automatic test_random_streams(input int phases, input int per_phase);
        int               len_pick [12];
        logic [7:0]       alpha [3];
        int               asize;
        int               n;
        int               r;
        int               cut;
        int               first_reg;
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
        logic [LEN_W-1:0] len_val;
        logic [7:0]       pb;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0] data;
        logic [7:0]       text_q[$];
        len_pick = '{16, 1, 31, 0, 2, 17, 5, 16, 3, 9, 4, 12};
        for (int p = 0; p < phases; p++)
        begin
            wait_idle();
            idle_on = !(p == 3 || p == 8);
            asize = $urandom_range(1, 3);
            for (int a = 0; a < 3; a++)
                alpha[a] = 8'($urandom);
            if (p == 1)
            begin
                alpha[0] = 8'h00;
                alpha[1] = 8'hFF;
                asize = 2;
            end
            len_val = (p < 12) ? LEN_W'(len_pick[p]) : LEN_W'($urandom_range(0, 31));
            for (int k = 0; k < PAT_BYTES; k++)
            begin
                pb = alpha[$urandom_range(0, asize - 1)];
                if (k >= len_val && $urandom_range(0, 1) == 1)
                    pb = 8'($urandom);
                if (k < 8)
                    lo[8*k +: 8] = pb;
                else
                    hi[8*(k-8) +: 8] = pb;
            end
            // registers in a rotating order, sometimes with a write past the list
            first_reg = $urandom_range(0, 2);
            for (int j = 0; j < 3; j++)
            begin
                case ((first_reg + j) % 3)
                    0: begin idx = CFG_PAT_LOW;  data = lo; end
                    1: begin idx = CFG_PAT_HIGH; data = hi; end
                    default: begin idx = CFG_PAT_LEN; data = CFG_W'(len_val); end
                endcase
                cfg_write(idx, data);
                if ($urandom_range(0, 3) == 0)
                    cfg_write(CFG_UNUSED, {$urandom, $urandom});
            end
            n = eff_len();
            text_q.delete();
            for (int i = 0; i < per_phase; i++)
            begin
                if (text_q.size() == 0)
                begin
                    r = $urandom_range(0, 9);
                    if (r < 5)
                        for (int k = 0; k < n; k++)
                            text_q.push_back(pat_at(k));
                    else if (r < 7)
                    begin
                        cut = $urandom_range(1, n);
                        for (int k = 0; k < cut; k++)
                            text_q.push_back(pat_at(k));
                    end
                    else if (r < 9)
                        text_q.push_back(alpha[$urandom_range(0, asize - 1)]);
                    else
                        text_q.push_back(8'($urandom));
                end
                // sender holds off mid-stream until all results are back
                if (p == 5 && i == per_phase / 2)
                    wait_idle();
                send_text(text_q.pop_front(),
                          (i == 0 && $urandom_range(0, 1) == 1) || $urandom_range(0, 63) == 0);
            end
        end
        idle_on = 1'b1;
    endtask

    // result beat checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_matches.size() == 0)
                report_mismatch($sformatf("result beat with nothing pending: found=%0b start=%0d",
                                          match_found, match_start));
            else
            begin
                want = expected_matches.pop_front();
                if (match_found !== want.found)
                    report_mismatch($sformatf("match_found got %0b want %0b",
                                              match_found, want.found));
                if (match_start !== want.start)
                    report_mismatch($sformatf("match_start got %0d want %0d",
                                              match_start, want.start));
            end
        end
    end

    // receiver with a random stall per result beat while idle_on is set
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            ready_stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (ready_stall > 0)
            begin
                @(negedge clk);
                out_ready = 1'b0;
                repeat (ready_stall - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        text_byte     = '0;
        first_of_text = 1'b0;
        pattern_lo      = '0;
        pattern_hi      = '0;
        pattern_len_reg = LEN_W'(1);
        next_pos        = '0;
        rebuild_failure();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_pattern();
        test_long_pattern();
        test_match_state();
        test_random_streams(12, 128);

        wait_idle();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
